/* rtl/plb_pkg.sv */
`default_nettype none

package plb_pkg;

   // operation codes
   localparam logic [2:0] OP_APPEND_TAIL  = 3'd0;
   localparam logic [2:0] OP_INSERT_HEAD  = 3'd1;
   localparam logic [2:0] OP_INSERT_AT    = 3'd2;
   localparam logic [2:0] OP_REMOVE_TAIL  = 3'd3;
   localparam logic [2:0] OP_REMOVE_HEAD  = 3'd4;
   localparam logic [2:0] OP_REMOVE_AT    = 3'd5;

   // status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_EMPTY    = 2'd1;
   localparam logic [1:0] STS_NO_ENTRY = 2'd2;
   localparam logic [1:0] STS_FULL     = 2'd3;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] value;
      logic [7:0] position;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] removed_value;
      logic [1:0] status;
      logic [6:0] entry_count;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } done_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } seq_state_type;

endpackage

`default_nettype wire

/* rtl/plb_mem.sv */
`default_nettype none

module plb_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/plb_ctrl.sv */
`default_nettype none

module plb_ctrl #(
   parameter int CAPACITY = 16,
   parameter int AW       = 4,
   parameter int CW       = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_fire,
   input  wire plb_pkg::req_payload_type req_payload,
   output logic                         idle,
   input  wire logic                    out_free,
   output plb_pkg::done_type            done,
   output logic                         mem_wr_en,
   output logic [AW-1:0]                mem_wr_addr,
   output logic [7:0]                   mem_wr_data,
   output logic                         mem_rd_en,
   output logic [AW-1:0]                mem_rd_addr,
   input  wire logic [7:0]              mem_rd_data
);

   import plb_pkg::*;

   seq_state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          ins_ff, ins_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [7:0]    value_ff, value_in;
   logic [7:0]    removed_ff, removed_in;
   logic [1:0]    status_ff, status_in;

   // request decode
   logic [7:0]    pos_eff;
   logic [7:0]    pm1;
   logic [7:0]    count8;
   logic          full;
   logic          empty;
   logic          act_d;
   logic          ins_d;
   logic [AW-1:0] idx_d;
   logic [1:0]    status_d;
   logic [CW-1:0] count_d;
   logic          last_step;

   always_comb begin
      pos_eff  = (req_payload.position == 8'd0) ? 8'd1 : req_payload.position;
      pm1      = pos_eff - 8'd1;
      count8   = 8'(count_ff);
      full     = (count_ff == CW'(CAPACITY));
      empty    = (count_ff == '0);
      act_d    = 1'b0;
      ins_d    = 1'b0;
      idx_d    = '0;
      status_d = STS_OK;
      count_d  = count_ff;
      unique case (req_payload.operation)
         OP_APPEND_TAIL, OP_INSERT_HEAD, OP_INSERT_AT: begin
            if (full) begin
               status_d = STS_FULL;
            end else begin
               act_d   = 1'b1;
               ins_d   = 1'b1;
               count_d = count_ff + CW'(1);
               if (req_payload.operation == OP_APPEND_TAIL) begin
                  idx_d = AW'(count_ff);
               end else if (req_payload.operation == OP_INSERT_HEAD) begin
                  idx_d = '0;
               end else if (pm1 > count8) begin
                  idx_d = AW'(count_ff);
               end else begin
                  idx_d = AW'(pm1);
               end
            end
         end
         OP_REMOVE_TAIL, OP_REMOVE_HEAD: begin
            if (empty) begin
               status_d = STS_EMPTY;
            end else begin
               act_d   = 1'b1;
               count_d = count_ff - CW'(1);
               idx_d   = (req_payload.operation == OP_REMOVE_TAIL) ?
                         AW'(count_ff - CW'(1)) : '0;
            end
         end
         OP_REMOVE_AT: begin
            if (empty) begin
               status_d = STS_EMPTY;
            end else if (pos_eff > count8) begin
               status_d = STS_NO_ENTRY;
            end else begin
               act_d   = 1'b1;
               count_d = count_ff - CW'(1);
               idx_d   = AW'(pm1);
            end
         end
         default: begin
         end
      endcase
   end

   assign last_step = !pend_ff && (remain_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = act_d ? S_RUN : S_DONE;
            end
         end
         S_RUN: begin
            if (last_step) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      remain_in    = remain_ff;
      idx_in       = idx_ff;
      ins_in       = ins_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      value_in     = value_ff;
      removed_in   = removed_ff;
      status_in    = status_ff;
      if (state_ff == S_IDLE && req_fire) begin
         count_in   = count_d;
         idx_in     = idx_d;
         ins_in     = ins_d;
         value_in   = req_payload.value;
         removed_in = 8'd0;
         status_in  = status_d;
         pend_in    = 1'b0;
         // number of entries to read equals count minus the slot index
         remain_in  = count_ff - CW'(idx_d);
         ptr_in     = ins_d ? AW'(count_ff - CW'(1)) : idx_d;
      end else if (state_ff == S_RUN) begin
         if (pend_ff && !ins_ff && pend_addr_ff == idx_ff) begin
            removed_in = mem_rd_data;
         end
         if (remain_ff != '0) begin
            pend_in      = 1'b1;
            pend_addr_in = ptr_ff;
            ptr_in       = ins_ff ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
            remain_in    = remain_ff - CW'(1);
         end else begin
            pend_in = 1'b0;
         end
      end
   end

   // outputs
   always_comb begin
      idle        = (state_ff == S_IDLE);
      mem_rd_en   = (state_ff == S_RUN) && (remain_ff != '0);
      mem_rd_addr = ptr_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff;
      mem_wr_data = value_ff;
      if (state_ff == S_RUN) begin
         if (pend_ff && (ins_ff || pend_addr_ff != idx_ff)) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ins_ff ? pend_addr_ff + AW'(1) : pend_addr_ff - AW'(1);
            mem_wr_data = mem_rd_data;
         end else if (last_step && ins_ff) begin
            mem_wr_en = 1'b1;
         end
      end
      done.valid                 = (state_ff == S_DONE);
      done.payload.removed_value = removed_ff;
      done.payload.status        = status_ff;
      done.payload.entry_count   = 7'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      remain_ff    <= remain_in;
      idx_ff       <= idx_in;
      ins_ff       <= ins_in;
      pend_addr_ff <= pend_addr_in;
      value_ff     <= value_in;
      removed_ff   <= removed_in;
      status_ff    <= status_in;
   end

endmodule

`default_nettype wire

/* rtl/positional_list_buffer_core.sv */
`default_nettype none

// ordered byte list of up to CAPACITY entries held in a single-port-write,
// registered-read memory. one request at a time: append at tail, insert at
// head, insert at a 1-based position (past the end appends, 0 means 1),
// remove tail, remove head, remove at position. each request gives one
// response with the removed byte, a status (ok, empty, no entry, full) and
// the new entry count. a request that moves entries walks them one per cycle
// through the memory with one shared address stepper. with slot index i on a
// list of n entries, the sequencer reads n - i entries (for a removal this
// includes the removed one). an append at the tail moves nothing, and
// requests that are rejected or ignored go straight to their response.
// req_stall is high from acceptance until the response is loaded into the
// output register, and the next request can be accepted in the cycle after
// that load. the output register holds the response while rsp_stall is high;
// the next request can be accepted while that response waits, but a
// finished request cannot load while the register is still held.
// no clearing pass is needed after reset.

module positional_list_buffer_core #(
   parameter int CAPACITY = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire plb_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output plb_pkg::rsp_payload_type      rsp_payload
);

   import plb_pkg::*;

   // memory address and entry count widths
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic            idle;
   logic            req_fire;
   logic            out_free;
   done_type        done;

   logic            mem_wr_en;
   logic [AW-1:0]   mem_wr_addr;
   logic [7:0]      mem_wr_data;
   logic            mem_rd_en;
   logic [AW-1:0]   mem_rd_addr;
   logic [7:0]      mem_rd_data;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // request side: only take a request when the sequencer is parked
   assign req_stall = !idle;
   assign req_fire  = req_valid && !req_stall;

   // output register can take a new response when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   plb_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_payload (req_payload),
      .idle        (idle),
      .out_free    (out_free),
      .done        (done),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // entry storage, contents undefined until written
   plb_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // response register load and drain
   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (done.valid && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = done.payload;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // an accepted request always keeps the input side closed next cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one in flight");

   // full status only when the list is at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == STS_FULL) |->
      (rsp_payload.entry_count == 7'(CAPACITY)))
      else $error("full status with list below capacity");

   // error responses never carry a removed byte (insert responses are not checked)
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != STS_OK) |->
      (rsp_payload.removed_value == 8'd0))
      else $error("removed byte on error response");

endmodule

`default_nettype wire

/* dv/tb_positional_list_buffer_core.sv */
`timescale 1ns / 100ps

module tb_positional_list_buffer_core;
   import plb_pkg::*;

   localparam int LIST_CAPACITY = 16;
   localparam int QUIET_TAIL    = 150;   // last requests go without any idling
   localparam int SETTLE_CYCLES = 40;    // idle time after the last response, longer than the longest move

   // codes the block must ignore
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      req_payload_type item;
      bit              drain_first;   // hold back until every response is in
   } queued_request_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   // requests waiting to go out, responses the list should still give
   queued_request_type pending_requests[$];
   rsp_payload_type    list_responses_due[$];

   // shadow copy of the list contents
   logic [7:0] list_store [LIST_CAPACITY];
   int         list_len = 0;

   int error_count   = 0;
   int sent_count    = 0;
   int checked_count = 0;
   int full_hits     = 0;
   int empty_hits    = 0;
   int missing_hits  = 0;
   int deepest_fill  = 0;

   positional_list_buffer_core #(
      .CAPACITY (LIST_CAPACITY)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // applies one request to the shadow list and returns the response it earns
   function automatic rsp_payload_type apply_list_op(input req_payload_type rq);
      rsp_payload_type rs;
      int              pos;
      int              slot;
      rs = '0;
      // position zero counts as the head
      pos = (rq.position == 8'd0) ? 1 : int'(rq.position);
      case (rq.operation)
         OP_APPEND_TAIL, OP_INSERT_HEAD, OP_INSERT_AT: begin
            if (list_len >= LIST_CAPACITY) begin
               // no room: dropped, nothing moves
               rs.status = STS_FULL;
            end else begin
               if (rq.operation == OP_APPEND_TAIL) slot = list_len;
               else if (rq.operation == OP_INSERT_HEAD) slot = 0;
               else slot = (pos - 1 > list_len) ? list_len : pos - 1;   // past the end appends
               for (int i = list_len; i > slot; i--) list_store[i] = list_store[i - 1];
               list_store[slot] = rq.value;
               list_len++;
            end
         end
         OP_REMOVE_TAIL, OP_REMOVE_HEAD, OP_REMOVE_AT: begin
            if (list_len == 0) begin
               rs.status = STS_EMPTY;
            end else if (rq.operation == OP_REMOVE_AT && pos > list_len) begin
               rs.status = STS_NO_ENTRY;
            end else begin
               if (rq.operation == OP_REMOVE_TAIL) slot = list_len - 1;
               else if (rq.operation == OP_REMOVE_HEAD) slot = 0;
               else slot = pos - 1;
               rs.removed_value = list_store[slot];
               for (int i = slot; i + 1 < list_len; i++) list_store[i] = list_store[i + 1];
               list_len--;
            end
         end
         default: begin
            // spare codes leave everything alone
         end
      endcase
      rs.entry_count = 7'(list_len);
      return rs;
   endfunction

   task automatic add_request(input logic [2:0] op, input logic [7:0] val,
                              input logic [7:0] pos, input bit drain = 1'b0);
      queued_request_type qr;
      qr.item.operation = op;
      qr.item.value     = val;
      qr.item.position  = pos;
      qr.drain_first    = drain;
      pending_requests.push_back(qr);
   endtask

   // ---------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------
   int                 send_gap  = 0;
   int                 send_mode = 1;
   int                 send_pct;
   queued_request_type next_request;

   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
      end else begin
         // request taken this edge: predict its response now
         if (req_valid && !req_stall) begin
            list_responses_due.push_back(apply_list_op(req_payload));
            sent_count++;
         end
         // now and then switch between no idling, light and heavy idling
         if ($urandom_range(0, 199) == 0) send_mode = $urandom_range(0, 2);
         send_pct = (send_mode == 0) ? 0 : (send_mode == 1) ? 8 : 30;
         // payload only moves once the current request is gone
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > QUIET_TAIL &&
                         $urandom_range(0, 99) < send_pct) begin
               send_gap = $urandom_range(1, 15) - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain_first &&
                           list_responses_due.size() != 0)) begin
               next_request = pending_requests.pop_front();
               req_valid   <= 1'b1;
               req_payload <= next_request.item;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // response monitor and stall generator
   // ---------------------------------------------------------------
   int              stall_left = 0;
   int              stall_mode = 1;
   int              stall_pct;
   rsp_payload_type want_rsp;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (list_responses_due.size() == 0) begin
               $error("response with nothing outstanding: removed_value %0d status %0d count %0d",
                      rsp_payload.removed_value, rsp_payload.status, rsp_payload.entry_count);
               error_count++;
            end else begin
               want_rsp = list_responses_due.pop_front();
               checked_count++;
               if (rsp_payload.removed_value !== want_rsp.removed_value) begin
                  $error("removed_value: expected %0d, actual %0d",
                         want_rsp.removed_value, rsp_payload.removed_value);
                  error_count++;
               end
               if (rsp_payload.status !== want_rsp.status) begin
                  $error("status: expected %0d, actual %0d", want_rsp.status, rsp_payload.status);
                  error_count++;
               end
               if (rsp_payload.entry_count !== want_rsp.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d",
                         want_rsp.entry_count, rsp_payload.entry_count);
                  error_count++;
               end
               // tally what the run got into
               if (want_rsp.status == STS_FULL) full_hits++;
               if (want_rsp.status == STS_EMPTY) empty_hits++;
               if (want_rsp.status == STS_NO_ENTRY) missing_hits++;
               if (int'(want_rsp.entry_count) > deepest_fill) deepest_fill = want_rsp.entry_count;
            end
         end
         // stall bursts, none started once the tail of the stimulus is reached
         if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
         stall_pct = (stall_mode == 0) ? 0 : (stall_mode == 1) ? 8 : 30;
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (pending_requests.size() > QUIET_TAIL &&
                      $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------
   int          shadow_len;
   bit          growing;
   int          pick;
   logic [2:0]  rnd_op;
   logic [7:0]  rnd_pos;
   int          eff_pos;

   initial begin
      // directed: removals from an empty list
      add_request(OP_REMOVE_TAIL, 8'hFF, 8'hFF);
      add_request(OP_REMOVE_HEAD, 8'h00, 8'h00);
      add_request(OP_REMOVE_AT,   8'hAA, 8'h00);
      // insert into an empty list at position zero, then past the end
      add_request(OP_INSERT_AT,   8'hFF, 8'h00);
      add_request(OP_INSERT_AT,   8'h00, 8'hFF);
      add_request(OP_APPEND_TAIL, 8'hA5, 8'h00);
      add_request(OP_INSERT_HEAD, 8'h5A, 8'hFF);
      add_request(OP_INSERT_AT,   8'h3C, 8'd2);
      // remove past the end, then at position zero
      add_request(OP_REMOVE_AT,   8'h00, 8'hFF);
      add_request(OP_REMOVE_AT,   8'h00, 8'h00);
      // spare codes
      add_request(OP_SPARE_6,     8'hFF, 8'hFF);
      add_request(OP_SPARE_7,     8'h00, 8'h00);
      // fill up to capacity (four held now)
      for (int i = 0; i < LIST_CAPACITY - 4; i++) begin
         if (i % 3 == 0) add_request(OP_APPEND_TAIL, 8'(i * 37 + 1), 8'h00);
         else if (i % 3 == 1) add_request(OP_INSERT_HEAD, 8'(i * 53 + 2), 8'h00);
         else add_request(OP_INSERT_AT, 8'(i * 71 + 3), 8'(i % 5 + 1));
      end
      // inserts when full, last slot by position, tail removal
      add_request(OP_INSERT_AT,   8'h77, 8'h00);
      add_request(OP_APPEND_TAIL, 8'h11, 8'h00);
      add_request(OP_REMOVE_AT,   8'h00, 8'(LIST_CAPACITY));
      add_request(OP_REMOVE_TAIL, 8'h00, 8'h00);

      // random: fill and drain cycles, so full and empty both come up often
      shadow_len = LIST_CAPACITY - 2;
      growing    = 1'b0;
      for (int n = 0; n < 1725; n++) begin
         if (shadow_len == LIST_CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
         if (shadow_len == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
         if ($urandom_range(0, 99) == 0) growing = ~growing;
         pick = $urandom_range(0, 99);
         if (pick < 2) rnd_op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
         else if ((pick < 70) == growing)
            rnd_op = ($urandom_range(0, 2) == 0) ? OP_APPEND_TAIL :
                     ($urandom_range(0, 1) == 0) ? OP_INSERT_HEAD : OP_INSERT_AT;
         else
            rnd_op = ($urandom_range(0, 2) == 0) ? OP_REMOVE_TAIL :
                     ($urandom_range(0, 1) == 0) ? OP_REMOVE_HEAD : OP_REMOVE_AT;
         // positions mostly near the live range, sometimes anywhere
         if ($urandom_range(0, 99) < 75) rnd_pos = 8'($urandom_range(0, shadow_len + 2));
         else rnd_pos = 8'($urandom_range(0, 255));
         add_request(rnd_op, 8'($urandom_range(0, 255)), rnd_pos, n == 600);
         // keep the length estimate used for shaping
         eff_pos = (rnd_pos == 8'd0) ? 1 : int'(rnd_pos);
         if (rnd_op == OP_APPEND_TAIL || rnd_op == OP_INSERT_HEAD ||
             rnd_op == OP_INSERT_AT) begin
            if (shadow_len < LIST_CAPACITY) shadow_len++;
         end else if (rnd_op == OP_REMOVE_TAIL || rnd_op == OP_REMOVE_HEAD) begin
            if (shadow_len > 0) shadow_len--;
         end else if (rnd_op == OP_REMOVE_AT) begin
            if (shadow_len > 0 && eff_pos <= shadow_len) shadow_len--;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // wait for the last request to go and every response to arrive
      while (pending_requests.size() != 0 || req_valid || list_responses_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d requests sent, %0d responses checked, list depth reached %0d",
               sent_count, checked_count, deepest_fill);
      $display("full rejections %0d, empty removals %0d, missing positions %0d",
               full_hits, empty_hits, missing_hits);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("timeout: %0d requests still queued, %0d responses outstanding",
               pending_requests.size(), list_responses_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
